// ----- hdl/wvcm_pkg.sv -----
// ----------------------------------------------------------------------------
// wvcm_pkg
// Shared types, constants and helper functions for the wind-vane circular
// mean block: CORDIC word formats, arctangent steps and Q1.15 rounding.
// ----------------------------------------------------------------------------
package wvcm_pkg;

  // Samples per averaging block (1 to 256).
  localparam int unsigned SAMPLES = 10;
  localparam int CNT_W  = 8;

  // CORDIC datapath widths and iteration count.
  localparam int XY_W   = 34;
  localparam int Z_W    = 25;
  localparam int ITER_W = 4;
  localparam logic [ITER_W-1:0] ITER_LAST = 4'd15;

  typedef logic signed [XY_W-1:0] xy_t;
  typedef logic signed [Z_W-1:0]  ang_t;

  typedef struct packed {
    logic              vectoring;
    logic [ITER_W-1:0] iter;
  } cordic_ctl_t;

  // Phase correction: raw * 360 - offset * 4096, taken modulo 1474560.
  localparam logic [22:0] RAW_SCALE = 23'd360;
  localparam logic [22:0] WRAP_BIAS = 23'd2949120;
  localparam logic [22:0] TURN      = 23'd1474560;

  // floor(n / 45) by reciprocal, then one correction step.
  localparam logic [22:0] RECIP_45  = 23'd5965232;
  localparam logic [21:0] DIV_45    = 22'd45;

  localparam xy_t  X_INIT    = 34'sd652032874;
  localparam ang_t HALF_TURN = 25'sd8388608;

  // Arctangent of 2^-i in units of 2^-24 turn.
  function automatic ang_t arc_step(input logic [ITER_W-1:0] i);
    ang_t a;
    case (i)
      4'd0:    a = 25'sd2097152;
      4'd1:    a = 25'sd1238021;
      4'd2:    a = 25'sd654136;
      4'd3:    a = 25'sd332050;
      4'd4:    a = 25'sd166669;
      4'd5:    a = 25'sd83416;
      4'd6:    a = 25'sd41718;
      4'd7:    a = 25'sd20860;
      4'd8:    a = 25'sd10430;
      4'd9:    a = 25'sd5215;
      4'd10:   a = 25'sd2608;
      4'd11:   a = 25'sd1304;
      4'd12:   a = 25'sd652;
      4'd13:   a = 25'sd326;
      4'd14:   a = 25'sd163;
      default: a = 25'sd81;
    endcase
    return a;
  endfunction

  // Round a scale-2^30 value to Q1.15 and clamp to +/-32767.
  function automatic logic signed [15:0] to_q15(input xy_t v);
    xy_t                t;
    logic signed [18:0] r;
    logic signed [15:0] q;
    t = v + 34'sd16384;
    r = signed'(t[XY_W-1:15]);
    if (r > 19'sd32767) begin
      q = 16'sd32767;
    end else if (r < -19'sd32767) begin
      q = -16'sd32767;
    end else begin
      q = r[15:0];
    end
    return q;
  endfunction

endpackage

// ----- hdl/wind_vane_circular_mean.sv -----
// ----------------------------------------------------------------------------
// wind_vane_circular_mean
// Corrects encoder samples for a north offset, accumulates their sine and
// cosine, and after each block of samples emits the circular mean direction
// and its 16-point compass sector.
//
//   channel  | direction | handshake           | payload
//   ---------+-----------+---------------------+-------------------------------
//   in_      | input     | in_valid/in_ready   | in_raw_angle[11:0]
//   out_     | output    | out_valid/out_ready | out_mean_angle, out_compass_sector
//   cfg_     | input     | cfg_wr_en           | cfg_wr_data[8:0] (north offset)
//
// A transfer leaves the block busy until it is back in idle: phase correction
// and division (MOD1, MOD2, MUL, FIX), sixteen rotation steps on the shared
// CORDIC step unit, and an accumulate state. A sample that closes a block adds
// a load, 16 vectoring steps and an output state, or only the load and the
// output state when both sums are zero. The output state waits while
// an earlier result sits unaccepted. Reset is synchronous, active low.
// ----------------------------------------------------------------------------
module wind_vane_circular_mean (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [8:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [11:0] in_raw_angle,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_mean_angle,
  output logic [3:0]  out_compass_sector
);
  import wvcm_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MOD1  = 4'd1;
  localparam logic [3:0] S_MOD2  = 4'd2;
  localparam logic [3:0] S_MUL   = 4'd3;
  localparam logic [3:0] S_FIX   = 4'd4;
  localparam logic [3:0] S_ROT   = 4'd5;
  localparam logic [3:0] S_ACC   = 4'd6;
  localparam logic [3:0] S_VLOAD = 4'd7;
  localparam logic [3:0] S_VEC   = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;

  logic [3:0]         state_r, state_nxt;
  logic [8:0]         north_offset_r, north_offset_nxt;
  logic [22:0]        wrap_r, wrap_nxt;
  logic [15:0]        q0_r, q0_nxt;
  logic [1:0]         quad_r, quad_nxt;
  logic [ITER_W-1:0]  iter_r, iter_nxt;
  xy_t                x_r, x_nxt;
  xy_t                y_r, y_nxt;
  ang_t               z_r, z_nxt;
  logic signed [23:0] sine_sum_r, sine_sum_nxt;
  logic signed [23:0] cosine_sum_r, cosine_sum_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               zero_r, zero_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [15:0]        mean_r, mean_nxt;
  logic [3:0]         sector_r, sector_nxt;

  cordic_ctl_t        step_ctl;
  xy_t                step_x, step_y;
  ang_t               step_z;

  logic [22:0]        wrap_in;
  logic [22:0]        wrap_red;
  logic [21:0]        dividend;
  logic [44:0]        prod;
  logic [21:0]        rem;
  logic [15:0]        phase;
  logic [15:0]        shifted;
  logic [13:0]        z_frac;
  logic signed [15:0] cos_q, sin_q, cos_val, sin_val;
  logic               block_end;
  xy_t                cx_ext, sy_ext;
  ang_t               z_round;
  logic [15:0]        mean_val;
  logic [15:0]        sector_sum;
  logic               out_free;

  wvcm_cordic_step u_step (
    .ctl (step_ctl),
    .x_i (x_r),
    .y_i (y_r),
    .z_i (z_r),
    .x_o (step_x),
    .y_o (step_y),
    .z_o (step_z)
  );

  assign step_ctl.vectoring = (state_r == S_VEC);
  assign step_ctl.iter      = iter_r;

  assign in_ready           = (state_r == S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_mean_angle     = mean_r;
  assign out_compass_sector = sector_r;

  // The biased sum stays positive and below three turns, so two
  // conditional subtractions complete the modulo.
  assign wrap_in  = 23'(in_raw_angle) * RAW_SCALE + WRAP_BIAS
                    - {2'b00, north_offset_r, 12'h000};
  assign wrap_red = (wrap_r >= TURN) ? (wrap_r - TURN) : wrap_r;

  // The reciprocal quotient is at most one short of floor(n / 45).
  assign dividend = {wrap_r[20:0], 1'b0};
  assign prod     = {23'd0, dividend} * {22'd0, RECIP_45};
  assign rem      = dividend - 22'(q0_r) * DIV_45;
  assign phase    = (rem >= DIV_45) ? (q0_r + 16'd1) : q0_r;
  assign shifted  = phase + 16'd8192;
  // Low 14 bits minus 8192, as a signed value, is the top bit inverted.
  assign z_frac   = {~shifted[13], shifted[12:0]};

  assign cos_q = to_q15(x_r);
  assign sin_q = to_q15(y_r);

  always_comb begin
    case (quad_r)
      2'd0: begin
        cos_val = cos_q;
        sin_val = sin_q;
      end
      2'd1: begin
        cos_val = -sin_q;
        sin_val = cos_q;
      end
      2'd2: begin
        cos_val = -cos_q;
        sin_val = -sin_q;
      end
      default: begin
        cos_val = sin_q;
        sin_val = -cos_q;
      end
    endcase
  end

  assign block_end = ((9'(count_r) + 9'd1) >= 9'(SAMPLES));

  assign cx_ext = {{(XY_W-24){cosine_sum_r[23]}}, cosine_sum_r};
  assign sy_ext = {{(XY_W-24){sine_sum_r[23]}}, sine_sum_r};

  assign z_round    = z_r + 25'sd128;
  assign mean_val   = zero_r ? 16'd0 : z_round[23:8];
  assign sector_sum = mean_val + 16'd2048;
  assign out_free   = !out_valid_r || out_ready;

  always_comb begin
    state_nxt        = state_r;
    north_offset_nxt = cfg_wr_en ? cfg_wr_data : north_offset_r;
    wrap_nxt         = wrap_r;
    q0_nxt           = q0_r;
    quad_nxt         = quad_r;
    iter_nxt         = iter_r;
    x_nxt            = x_r;
    y_nxt            = y_r;
    z_nxt            = z_r;
    sine_sum_nxt     = sine_sum_r;
    cosine_sum_nxt   = cosine_sum_r;
    count_nxt        = count_r;
    zero_nxt         = zero_r;
    out_valid_nxt    = out_valid_r && !out_ready;
    mean_nxt         = mean_r;
    sector_nxt       = sector_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          wrap_nxt  = wrap_in;
          state_nxt = S_MOD1;
        end
      end
      S_MOD1: begin
        wrap_nxt  = wrap_red;
        state_nxt = S_MOD2;
      end
      S_MOD2: begin
        wrap_nxt  = wrap_red;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        q0_nxt    = prod[43:28];
        state_nxt = S_FIX;
      end
      S_FIX: begin
        quad_nxt  = shifted[15:14];
        x_nxt     = X_INIT;
        y_nxt     = '0;
        z_nxt     = {{3{z_frac[13]}}, z_frac, 8'h00};
        iter_nxt  = '0;
        state_nxt = S_ROT;
      end
      S_ROT: begin
        x_nxt    = step_x;
        y_nxt    = step_y;
        z_nxt    = step_z;
        iter_nxt = iter_r + 4'd1;
        if (iter_r == ITER_LAST) begin
          state_nxt = S_ACC;
        end
      end
      S_ACC: begin
        sine_sum_nxt   = sine_sum_r + {{8{sin_val[15]}}, sin_val};
        cosine_sum_nxt = cosine_sum_r + {{8{cos_val[15]}}, cos_val};
        if (block_end) begin
          count_nxt = '0;
          state_nxt = S_VLOAD;
        end else begin
          count_nxt = count_r + 8'd1;
          state_nxt = S_IDLE;
        end
      end
      S_VLOAD: begin
        iter_nxt = '0;
        if (sine_sum_r == 24'sd0 && cosine_sum_r == 24'sd0) begin
          zero_nxt  = 1'b1;
          state_nxt = S_OUT;
        end else begin
          zero_nxt = 1'b0;
          // A vector in the left half-plane is turned by half a turn first.
          if (cosine_sum_r[23]) begin
            x_nxt = (-cx_ext) <<< 8;
            y_nxt = (-sy_ext) <<< 8;
            z_nxt = HALF_TURN;
          end else begin
            x_nxt = cx_ext <<< 8;
            y_nxt = sy_ext <<< 8;
            z_nxt = '0;
          end
          state_nxt = S_VEC;
        end
      end
      S_VEC: begin
        x_nxt    = step_x;
        y_nxt    = step_y;
        z_nxt    = step_z;
        iter_nxt = iter_r + 4'd1;
        if (iter_r == ITER_LAST) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          mean_nxt       = mean_val;
          sector_nxt     = sector_sum[15:12];
          sine_sum_nxt   = '0;
          cosine_sum_nxt = '0;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      north_offset_r <= '0;
      sine_sum_r     <= '0;
      cosine_sum_r   <= '0;
      count_r        <= '0;
      zero_r         <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      north_offset_r <= north_offset_nxt;
      sine_sum_r     <= sine_sum_nxt;
      cosine_sum_r   <= cosine_sum_nxt;
      count_r        <= count_nxt;
      zero_r         <= zero_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wrap_r   <= wrap_nxt;
    q0_r     <= q0_nxt;
    quad_r   <= quad_nxt;
    iter_r   <= iter_nxt;
    x_r      <= x_nxt;
    y_r      <= y_nxt;
    z_r      <= z_nxt;
    mean_r   <= mean_nxt;
    sector_r <= sector_nxt;
  end

`ifndef SYNTHESIS
  // A transfer always starts a multi-cycle job, so ready drops at once.
  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input still ready after a transfer");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    (9'(count_r) < 9'(SAMPLES)))
    else $error("sample count beyond block length");

  a_sector_matches: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_compass_sector == 4'((out_mean_angle + 16'd2048) >> 12)))
    else $error("compass sector disagrees with mean angle");

  a_rot_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ROT && iter_r != ITER_LAST)
      |=> (state_r == S_ROT && iter_r == $past(iter_r) + 4'd1))
    else $error("rotation pass left early or skipped a step");

  a_vec_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_VEC && iter_r != ITER_LAST)
      |=> (state_r == S_VEC && iter_r == $past(iter_r) + 4'd1))
    else $error("vectoring pass left early or skipped a step");
`endif

endmodule

// ----- hdl/wvcm_cordic_step.sv -----
// ----------------------------------------------------------------------------
// wvcm_cordic_step
// One CORDIC micro-rotation, shared by the sine/cosine pass (rotation) and
// the atan2 pass (vectoring). The sequencer feeds the result back each cycle.
// ----------------------------------------------------------------------------
module wvcm_cordic_step (
  input  wvcm_pkg::cordic_ctl_t ctl,
  input  wvcm_pkg::xy_t         x_i,
  input  wvcm_pkg::xy_t         y_i,
  input  wvcm_pkg::ang_t        z_i,
  output wvcm_pkg::xy_t         x_o,
  output wvcm_pkg::xy_t         y_o,
  output wvcm_pkg::ang_t        z_o
);
  import wvcm_pkg::*;

  xy_t  xs;
  xy_t  ys;
  ang_t a;
  logic ccw;

  // Arithmetic shifts give the floor behaviour on negative values.
  assign xs = x_i >>> ctl.iter;
  assign ys = y_i >>> ctl.iter;
  assign a  = arc_step(ctl.iter);

  // Rotation follows the sign of z, vectoring drives y towards zero.
  assign ccw = ctl.vectoring ? y_i[XY_W-1] : ~z_i[Z_W-1];

  always_comb begin
    if (ccw) begin
      x_o = x_i - ys;
      y_o = y_i + xs;
      z_o = z_i - a;
    end else begin
      x_o = x_i + ys;
      y_o = y_i - xs;
      z_o = z_i + a;
    end
  end

endmodule
